// ===== hdl/bba_pkg.sv =====
package bba_pkg;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 9;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;

  localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_USED    = 2'd3;

  typedef struct packed {
    logic accept;
    logic scan_run;
    logic rmw_read;
    logic rmw_exec;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              in_range;
    logic              scan_hit;
    logic              scan_end;
  } dp_stat_t;

endpackage

// ===== hdl/bba_ctrl.sv =====
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  bba_pkg::dp_stat_t  stat,
  output bba_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RMW_RD,
    S_RMW_CHK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.in_kind == bba_pkg::KIND_ALLOCATE) begin
            state_nxt = S_SCAN;
          end else if ((stat.in_kind == bba_pkg::KIND_REQUEST ||
                        stat.in_kind == bba_pkg::KIND_RELEASE) && stat.in_range) begin
            state_nxt = S_RMW_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_hit || stat.scan_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RMW_RD: begin
        cmd.rmw_read = 1'b1;
        state_nxt    = S_RMW_CHK;
      end
      S_RMW_CHK: begin
        cmd.rmw_exec = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/bba_dpath.sv =====
module bba_dpath #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bba_pkg::KIND_W-1:0]      in_kind,
  input  logic [bba_pkg::INDEX_W-1:0]     in_index,
  input  bba_pkg::ctl_cmd_t               cmd,
  output bba_pkg::dp_stat_t               stat,
  output logic [bba_pkg::STAT_W-1:0]      out_status,
  output logic [bba_pkg::INDEX_W-1:0]     out_index,
  output logic [bba_pkg::COUNT_W-1:0]     out_used,
  output logic [bba_pkg::COUNT_W-1:0]     out_free
);

  localparam int NUM_WORDS = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int DEPTH     = 1 << AW;
  localparam int CW        = $clog2(NUM_BLOCKS + 1);
  localparam int LAST_BITS = NUM_BLOCKS - bba_pkg::WORD_W * (NUM_WORDS - 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [bba_pkg::WORD_W-1:0] LAST_MASK =
    (LAST_BITS == bba_pkg::WORD_W) ? '1 :
    ((bba_pkg::WORD_W)'(1) << LAST_BITS) - (bba_pkg::WORD_W)'(1);

  logic [bba_pkg::WORD_W-1:0] used_mem [DEPTH];
  logic [DEPTH-1:0]           wvalid_r;
  logic [bba_pkg::WORD_W-1:0] rdata_r;
  logic                       rd_wv_r;

  logic [bba_pkg::KIND_W-1:0]  kind_r;
  logic [bba_pkg::INDEX_W-1:0] idx_r;
  logic [AW-1:0]               rd_addr_r;
  logic [AW-1:0]               chk_addr_r;
  logic                        chk_v_r;
  logic [CW-1:0]               used_total_r, used_total_nxt;
  logic [bba_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [bba_pkg::INDEX_W-1:0] res_index_r, res_index_nxt;

  logic [bba_pkg::STAT_W-1:0]  out_status_r;
  logic [bba_pkg::INDEX_W-1:0] out_index_r;
  logic [bba_pkg::COUNT_W-1:0] out_used_r;
  logic [bba_pkg::COUNT_W-1:0] out_free_r;

  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               idx_word;
  logic [bba_pkg::WORD_W-1:0]  cur_word;
  logic [bba_pkg::WORD_W-1:0]  range_mask;
  logic [bba_pkg::WORD_W-1:0]  free_vec;
  logic [bba_pkg::WORD_W-1:0]  idx_mask;
  logic [bba_pkg::BIT_W-1:0]   hit_bit;
  logic                        any_free;
  logic                        idx_used;
  logic                        wr_en;
  logic [bba_pkg::WORD_W-1:0]  wr_data;

  assign idx_word = AW'(idx_r[bba_pkg::INDEX_W-1:bba_pkg::BIT_W]);
  assign rd_addr  = cmd.rmw_read ? idx_word : rd_addr_r;
  assign cur_word = rd_wv_r ? rdata_r : '0;

  // blocks past the end of the pool count as used
  always_comb begin
    if (chk_addr_r < LAST_WORD) begin
      range_mask = '1;
    end else if (chk_addr_r == LAST_WORD) begin
      range_mask = LAST_MASK;
    end else begin
      range_mask = '0;
    end
  end

  assign free_vec = ~cur_word & range_mask;
  assign any_free = |free_vec;

  always_comb begin
    hit_bit = '0;
    for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        hit_bit = bba_pkg::BIT_W'(b);
      end
    end
  end

  assign idx_mask = (bba_pkg::WORD_W)'(1) << idx_r[bba_pkg::BIT_W-1:0];
  assign idx_used = |(cur_word & idx_mask);

  assign stat.in_kind  = in_kind;
  assign stat.in_range = (int'(in_index) < NUM_BLOCKS);
  assign stat.scan_hit = cmd.scan_run && chk_v_r && any_free;
  assign stat.scan_end = cmd.scan_run && chk_v_r && !any_free && (chk_addr_r == LAST_WORD);

  always_comb begin
    wr_en          = 1'b0;
    wr_data        = cur_word;
    used_total_nxt = used_total_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    if (cmd.accept) begin
      res_index_nxt  = in_index;
      res_status_nxt = bba_pkg::ST_OK;
      if ((in_kind == bba_pkg::KIND_REQUEST || in_kind == bba_pkg::KIND_RELEASE) &&
          !stat.in_range) begin
        res_status_nxt = bba_pkg::ST_RANGE;
      end
    end else if (stat.scan_hit) begin
      wr_en          = 1'b1;
      wr_data        = cur_word | ((bba_pkg::WORD_W)'(1) << hit_bit);
      used_total_nxt = used_total_r + CW'(1);
      res_index_nxt  = bba_pkg::INDEX_W'({chk_addr_r, hit_bit});
    end else if (stat.scan_end) begin
      res_status_nxt = bba_pkg::ST_NO_FREE;
    end else if (cmd.rmw_exec) begin
      if (kind_r == bba_pkg::KIND_REQUEST) begin
        if (idx_used) begin
          res_status_nxt = bba_pkg::ST_USED;
        end else begin
          wr_en          = 1'b1;
          wr_data        = cur_word | idx_mask;
          used_total_nxt = used_total_r + CW'(1);
        end
      end else if (idx_used) begin
        wr_en          = 1'b1;
        wr_data        = cur_word & ~idx_mask;
        used_total_nxt = used_total_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[chk_addr_r] <= wr_data;
    end
    rdata_r <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r     <= '0;
      rd_wv_r      <= 1'b0;
      used_total_r <= '0;
      chk_v_r      <= 1'b0;
    end else begin
      rd_wv_r      <= wvalid_r[rd_addr];
      used_total_r <= used_total_nxt;
      if (wr_en) begin
        wvalid_r[chk_addr_r] <= 1'b1;
      end
      if (cmd.accept) begin
        chk_v_r <= 1'b0;
      end else if (cmd.scan_run) begin
        chk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    if (cmd.accept) begin
      kind_r    <= in_kind;
      idx_r     <= in_index;
      rd_addr_r <= '0;
    end else if (cmd.scan_run) begin
      rd_addr_r  <= rd_addr_r + AW'(1);
      chk_addr_r <= rd_addr_r;
    end else if (cmd.rmw_read) begin
      chk_addr_r <= idx_word;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_used_r   <= bba_pkg::COUNT_W'(used_total_r);
      out_free_r   <= bba_pkg::COUNT_W'(CW'(NUM_BLOCKS) - used_total_r);
    end
  end

  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_used   = out_used_r;
  assign out_free   = out_free_r;

endmodule

// ===== hdl/bitmap_block_allocator.sv =====
// Allocate: the map is scanned from word 0, one 32-bit map word per cycle, until the
// word holding the lowest free block is found or the last word shows the pool is full.
// Request and release: read, modify and write of one map word.
// A new item can be accepted while the result waits in the output register,
// so items are handled one at a time; a stalled output holds the next result back.
// Reset clears the per-word valid bits of the map and the used count.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind[1:0], block_index[9:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[1:0], granted_index[9:2], used_count[18:10],
                                  // free_count[27:19]
);

  bba_pkg::ctl_cmd_t cmd;
  bba_pkg::dp_stat_t stat;

  logic [bba_pkg::STAT_W-1:0]  res_status;
  logic [bba_pkg::INDEX_W-1:0] res_index;
  logic [bba_pkg::COUNT_W-1:0] res_used;
  logic [bba_pkg::COUNT_W-1:0] res_free;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_tdata[1:0]),
    .in_index   (in_tdata[9:2]),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (res_status),
    .out_index  (res_index),
    .out_used   (res_used),
    .out_free   (res_free)
  );

  assign out_tdata = {4'd0, res_free, res_used, res_index, res_status};

endmodule
